### rtl/lrfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfd_pkg
// Shared types and constants of the laser range frame decoder.
// ----------------------------------------------------------------------------
package lrfd_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DIST_W = 20;
  localparam int unsigned ACC_W  = 27;
  localparam int unsigned POS_W  = 4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [POS_W-1:0] pos_t;

  // frame layout
  localparam int unsigned FRAME_BYTES = 11;
  localparam pos_t POS_HUNT        = POS_W'(0);
  localparam pos_t POS_FIRST_DIGIT = POS_W'(3);
  localparam pos_t POS_SPACER      = POS_W'(6);
  localparam pos_t POS_LAST_DIGIT  = POS_W'(9);
  localparam pos_t POS_CHECKSUM    = POS_W'(FRAME_BYTES - 1);

  // byte codes
  localparam byte_t HEADER_BYTE = 8'h80;
  localparam byte_t DIGIT_BASE  = 8'd48;

  // reset value of the distance limit
  localparam dist_t LIMIT_RESET = DIST_W'(10000);

endpackage

### rtl/laser_range_frame_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_range_frame_decoder_top
// Decodes the serial byte stream of a laser range module into distances.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle. Bytes are dropped until the
// 0x80 header; then an 11-byte frame is collected with a running checksum
// and a decimal digit accumulator (multiply by ten and add, one digit per
// byte), so there is no frame buffer. A frame with a good checksum gives one
// item on the out channel in the cycle after its checksum byte is taken;
// a bad frame gives nothing. Sustained rate is one byte per cycle. The only
// stall is a checksum byte arriving while the single output register still
// holds an item the sink has not taken. The distance limit may be written
// only while no frame result is pending.
module laser_range_frame_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lrfd_pkg::DIST_W-1:0]    cfg_distance_limit,
  // received bytes
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lrfd_pkg::BYTE_W-1:0]    in_rx_byte,
  // decoded distances
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lrfd_pkg::DIST_W-1:0]    out_distance,
  output logic                           out_out_of_range
);

  lrfd_pkg::dist_t limit_r;
  lrfd_pkg::pos_t  pos_r, pos_nxt;
  lrfd_pkg::byte_t sum_r, sum_nxt;
  lrfd_pkg::acc_t  acc_r, acc_nxt;
  lrfd_pkg::dist_t last_r, last_nxt;

  logic            out_valid_r, out_valid_nxt;
  lrfd_pkg::dist_t out_dist_r, out_dist_nxt;
  logic            out_oor_r, out_oor_nxt;

  logic            in_fire;
  logic            out_free;
  logic            is_digit;
  logic            sum_ok;
  logic            too_big;
  logic            reject;
  lrfd_pkg::acc_t  digit;
  lrfd_pkg::acc_t  acc_x10;
  lrfd_pkg::byte_t sum_add;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lrfd_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_distance_limit;
    end
  end

  // handshake: only the checksum byte needs a free output slot
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = out_free || (pos_r != lrfd_pkg::POS_CHECKSUM);
  assign in_fire  = in_valid && in_ready;

  // per-byte arithmetic
  assign sum_add  = sum_r + in_rx_byte;
  assign digit    = lrfd_pkg::ACC_W'($signed({1'b0, in_rx_byte}))
                  - lrfd_pkg::ACC_W'(lrfd_pkg::DIGIT_BASE);
  assign acc_x10  = (acc_r <<< 3) + (acc_r <<< 1);
  assign is_digit = (pos_r >= lrfd_pkg::POS_FIRST_DIGIT) &&
                    (pos_r <= lrfd_pkg::POS_LAST_DIGIT) &&
                    (pos_r != lrfd_pkg::POS_SPACER);

  // checksum byte makes the whole frame sum zero
  assign sum_ok  = (sum_add == '0);
  assign too_big = acc_r > $signed({1'b0, {(lrfd_pkg::ACC_W-lrfd_pkg::DIST_W-1){1'b0}},
                                    limit_r});
  assign reject  = acc_r[lrfd_pkg::ACC_W-1] || too_big;

  // frame tracking
  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    acc_nxt  = acc_r;
    last_nxt = last_r;
    if (in_fire) begin
      if (pos_r == lrfd_pkg::POS_HUNT) begin
        if (in_rx_byte == lrfd_pkg::HEADER_BYTE) begin
          pos_nxt = lrfd_pkg::POS_W'(1);
          sum_nxt = in_rx_byte;
          acc_nxt = '0;
        end
      end else if (pos_r == lrfd_pkg::POS_CHECKSUM) begin
        pos_nxt = lrfd_pkg::POS_HUNT;
        if (sum_ok && !reject) begin
          last_nxt = acc_r[lrfd_pkg::DIST_W-1:0];
        end
      end else begin
        pos_nxt = pos_r + lrfd_pkg::POS_W'(1);
        sum_nxt = sum_add;
        if (is_digit) begin
          acc_nxt = acc_x10 + digit;
        end
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_dist_nxt  = out_dist_r;
    out_oor_nxt   = out_oor_r;
    if (in_fire && (pos_r == lrfd_pkg::POS_CHECKSUM) && sum_ok) begin
      out_valid_nxt = 1'b1;
      out_oor_nxt   = reject;
      out_dist_nxt  = reject ? last_r : acc_r[lrfd_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= lrfd_pkg::POS_HUNT;
      sum_r       <= '0;
      acc_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      acc_r       <= acc_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_dist_r <= out_dist_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_distance     = out_dist_r;
  assign out_out_of_range = out_oor_r;

endmodule

### rtl/lrfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfd_checker
// Port-level checks of the laser range frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lrfd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lrfd_pkg::DIST_W-1:0] out_distance,
  input logic                        out_out_of_range
);

  lrfd_pkg::dist_t last_ok_r;

  // last in-range distance delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ok_r <= '0;
    end else if (out_valid && out_ready && !out_out_of_range) begin
      last_ok_r <= out_distance;
    end
  end

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance)
      && $stable(out_out_of_range))
    else $error("output item changed while stalled");

  // a new item appears only after a byte was taken
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("output item without an accepted byte");

  // input stalls only behind a held output item
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with a free output slot");

  // a rejected value repeats the last good distance
  a_oor_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_distance == last_ok_r)
    else $error("out of range item does not repeat last distance");

endmodule

bind laser_range_frame_decoder_top lrfd_checker u_lrfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_distance     (out_distance),
  .out_out_of_range (out_out_of_range)
);

### bench/laser_range_frame_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_range_frame_decoder_top_test
// Self-checking bench for the laser range frame decoder. A table of directed
// bytes and frames runs first, then random frames, broken frames and line
// noise under several distance limits. Each item is checked in order against
// the bench decoder or table; both sides idle at random until the last phase.
// ----------------------------------------------------------------------------
module laser_range_frame_decoder_top_test;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES   = 140;
  localparam int PHASE_COUNT   = 6;
  localparam int MAX_REPORTS   = 10;
  localparam int DIGITS        = 6;
  localparam int DIST_MAX      = 999999;

  typedef struct packed {
    lrfd_pkg::dist_t distance;
    logic            out_of_range;
  } reading_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_FRAME, ROW_BAD_SUM} row_kind_t;

  // one directed row: a lone byte (in the low digit byte) or a whole frame
  typedef struct {
    row_kind_t       kind;
    logic [15:0]     lead;
    logic [47:0]     digits;
    lrfd_pkg::byte_t spacer;
    bit              typed;
    lrfd_pkg::dist_t want_distance;
    logic            want_oor;
  } row_t;

  logic            clk;
  logic            rst_n;
  logic            cfg_valid;
  logic            cfg_ready;
  lrfd_pkg::dist_t cfg_distance_limit;
  logic            in_valid;
  logic            in_ready;
  lrfd_pkg::byte_t in_rx_byte;
  logic            out_valid;
  logic            out_ready;
  lrfd_pkg::dist_t out_distance;
  logic            out_out_of_range;

  // bench copy of the decoder state
  lrfd_pkg::pos_t  frame_pos;
  lrfd_pkg::byte_t frame_sum;
  lrfd_pkg::acc_t  frame_value;
  lrfd_pkg::dist_t held_distance;
  lrfd_pkg::dist_t dist_limit;

  reading_t expected_readings[$];
  int       mismatch_count;
  int       cycle_count;
  int       bytes_sent;
  int       gap_rate;
  int       stall_rate;
  int       stall_left;
  bit       quiet;

  // directed stimulus, run with the reset limit and a zero held distance
  row_t directed_rows [0:18] = '{
    '{ROW_BYTE,    16'h0000, 48'h00,   8'h00, 1'b0, '0,                       1'b0},
    '{ROW_BYTE,    16'h0000, 48'hFF,   8'h00, 1'b0, '0,                       1'b0},
    '{ROW_BYTE,    16'h0000, 48'h7F,   8'h00, 1'b0, '0,                       1'b0},
    '{ROW_BYTE,    16'h0000, 48'h81,   8'h00, 1'b0, '0,                       1'b0},
    '{ROW_FRAME,   16'h0000, "000000", 8'h00, 1'b1, lrfd_pkg::dist_t'(0),     1'b0},
    '{ROW_FRAME,   16'hFFFF, "010000", 8'hFF, 1'b1, lrfd_pkg::dist_t'(10000), 1'b0},
    '{ROW_FRAME,   16'h1234, "010001", 8'h2E, 1'b1, lrfd_pkg::dist_t'(10000), 1'b1},
    '{ROW_FRAME,   16'hA55A, "999999", 8'h20, 1'b1, lrfd_pkg::dist_t'(10000), 1'b1},
    '{ROW_FRAME,   16'h0102, "/00000", 8'h2E, 1'b1, lrfd_pkg::dist_t'(10000), 1'b1},
    '{ROW_BAD_SUM, 16'h0000, "000123", 8'h2E, 1'b0, '0,                       1'b0},
    '{ROW_FRAME,   16'h8080, "000123", 8'h80, 1'b1, lrfd_pkg::dist_t'(123),   1'b0},
    '{ROW_FRAME,   16'h00FF, 48'h000000FFFFFF, 8'h80, 1'b0, '0,                1'b0},
    '{ROW_FRAME,   16'h7E81, "00:;<=", 8'h01, 1'b0, '0,                       1'b0},
    '{ROW_FRAME,   16'h3030, "009999", 8'h2E, 1'b1, lrfd_pkg::dist_t'(9999),  1'b0},
    '{ROW_FRAME,   16'h5AA5, "/99999", 8'h2E, 1'b1, lrfd_pkg::dist_t'(9999),  1'b1},
    '{ROW_BYTE,    16'h0000, 48'h55,   8'h00, 1'b0, '0,                       1'b0},
    '{ROW_FRAME,   16'hFF00, 48'hFFFFFFFFFFFF, 8'hFF, 1'b0, '0,                1'b0},
    '{ROW_BAD_SUM, 16'hFFFF, "999999", 8'hFF, 1'b0, '0,                       1'b0},
    '{ROW_FRAME,   16'h0000, "000001", 8'h00, 1'b1, lrfd_pkg::dist_t'(1),     1'b0}
  };

  laser_range_frame_decoder_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_distance_limit (cfg_distance_limit),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_distance       (out_distance),
    .out_out_of_range   (out_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // decode one received byte; a good checksum byte yields a reading
  task automatic predict_distance(input lrfd_pkg::byte_t b, output bit produced,
                                  output reading_t r);
    produced = 1'b0;
    r = '0;
    if (frame_pos == lrfd_pkg::POS_HUNT) begin
      if (b == lrfd_pkg::HEADER_BYTE) begin
        frame_sum = b;
        frame_value = '0;
        frame_pos = lrfd_pkg::pos_t'(1);
      end
    end else if (frame_pos < lrfd_pkg::POS_CHECKSUM) begin
      frame_sum = frame_sum + b;
      // digits fold in most significant first, the spacer is skipped
      if (frame_pos >= lrfd_pkg::POS_FIRST_DIGIT && frame_pos <= lrfd_pkg::POS_LAST_DIGIT
          && frame_pos != lrfd_pkg::POS_SPACER)
        frame_value = lrfd_pkg::acc_t'(int'(frame_value) * 10 + int'(b)
                                       - int'(lrfd_pkg::DIGIT_BASE));
      frame_pos = frame_pos + 1'b1;
    end else begin
      frame_pos = lrfd_pkg::POS_HUNT;
      if (lrfd_pkg::byte_t'(frame_sum + b) == 8'h00) begin
        produced = 1'b1;
        if (frame_value < 0 || int'(frame_value) > int'(dist_limit)) begin
          r.distance = held_distance;
          r.out_of_range = 1'b1;
        end else begin
          held_distance = lrfd_pkg::dist_t'(frame_value);
          r.distance = held_distance;
          r.out_of_range = 1'b0;
        end
      end
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // result side: check every taken item, stall in random bursts
  initial begin
    reading_t want;
    stall_left = 0;
    stall_rate = 2;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          note_mismatch($sformatf("unexpected item distance %0d out_of_range %0b",
                                  out_distance, out_out_of_range));
        end else begin
          want = expected_readings.pop_front();
          if (out_distance !== want.distance || out_out_of_range !== want.out_of_range)
            note_mismatch($sformatf("expected distance %0d out_of_range %0b, got %0d %0b",
                                    want.distance, want.out_of_range,
                                    out_distance, out_out_of_range));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0)
          out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) < stall_rate) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 11);
      end
      if ($urandom_range(0, 127) == 0)
        stall_rate = $urandom_range(0, 4);
    end
  end

  // hand one byte to the block, with an optional idle burst ahead of it
  task automatic send_byte(input lrfd_pkg::byte_t b, input bit typed = 1'b0,
                           input reading_t want = '0);
    bit       produced;
    reading_t got;
    if (!quiet && $urandom_range(0, 15) < gap_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    predict_distance(b, produced, got);
    if (produced)
      expected_readings.push_back(typed ? want : got);
  endtask

  // build a frame around six digit bytes and send it
  task automatic send_frame(input logic [47:0] digits, input logic [15:0] lead,
                            input lrfd_pkg::byte_t spacer, input bit corrupt,
                            input bit typed, input reading_t want);
    lrfd_pkg::byte_t frame [lrfd_pkg::FRAME_BYTES];
    lrfd_pkg::byte_t sum;
    int              k;
    frame[0] = lrfd_pkg::HEADER_BYTE;
    frame[1] = lead[15:8];
    frame[2] = lead[7:0];
    frame[lrfd_pkg::POS_SPACER] = spacer;
    for (k = 0; k < DIGITS; k++) begin
      if (k < 3)
        frame[lrfd_pkg::POS_FIRST_DIGIT + k] = digits[47 - 8 * k -: 8];
      else
        frame[lrfd_pkg::POS_SPACER + 1 + (k - 3)] = digits[47 - 8 * k -: 8];
    end
    sum = '0;
    for (k = 0; k < lrfd_pkg::FRAME_BYTES - 1; k++)
      sum = sum + frame[k];
    frame[lrfd_pkg::POS_CHECKSUM] = lrfd_pkg::byte_t'(8'h00 - sum);
    if (corrupt)
      frame[lrfd_pkg::POS_CHECKSUM] = frame[lrfd_pkg::POS_CHECKSUM]
                                      ^ lrfd_pkg::byte_t'($urandom_range(1, 255));
    for (k = 0; k < lrfd_pkg::FRAME_BYTES; k++)
      send_byte(frame[k], typed && (k == lrfd_pkg::FRAME_BYTES - 1), want);
  endtask

  function automatic logic [47:0] ascii_digits(input int value);
    logic [47:0] d;
    for (int k = 0; k < DIGITS; k++) begin
      d[8 * k +: 8] = lrfd_pkg::byte_t'(int'(lrfd_pkg::DIGIT_BASE) + value % 10);
      value = value / 10;
    end
    return d;
  endfunction

  // sender holds off until every reading is back and the block is quiet
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input lrfd_pkg::dist_t value);
    cfg_valid <= 1'b1;
    cfg_distance_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dist_limit = value;
  endtask

  // mostly well-formed frames with random content, some noise and bad sums
  task automatic run_phase(input int n_bytes);
    int          start;
    int          value;
    logic [47:0] digits;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 5)) send_byte(lrfd_pkg::byte_t'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: value = $urandom_range(0, dist_limit);
          5:             value = int'(dist_limit) + $urandom_range(0, 1);
          6, 7:          value = $urandom_range(0, DIST_MAX);
          default:       value = -1;
        endcase
        if (value < 0)
          digits = {32'($urandom()), 16'($urandom())};
        else
          digits = ascii_digits(value);
        send_frame(digits, 16'($urandom()), lrfd_pkg::byte_t'($urandom()),
                   $urandom_range(0, 7) == 0, 1'b0, '0);
      end
    end
    // run out any frame that noise may have opened
    while (frame_pos != lrfd_pkg::POS_HUNT)
      send_byte(lrfd_pkg::byte_t'($urandom_range(0, 255)));
  endtask

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("laser_range_frame_decoder_top regression: fail");
    $finish;
  end

  // main sequence
  initial begin
    lrfd_pkg::dist_t phase_limits [PHASE_COUNT];
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_distance_limit <= '0;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    out_ready <= 1'b1;
    quiet = 1'b0;
    gap_rate = 3;
    mismatch_count = 0;
    bytes_sent = 0;
    frame_pos = lrfd_pkg::POS_HUNT;
    frame_sum = '0;
    frame_value = '0;
    held_distance = '0;
    dist_limit = lrfd_pkg::LIMIT_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table under the reset limit
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_BYTE)
        send_byte(directed_rows[i].digits[7:0]);
      else
        send_frame(directed_rows[i].digits, directed_rows[i].lead, directed_rows[i].spacer,
                   directed_rows[i].kind == ROW_BAD_SUM, directed_rows[i].typed,
                   {directed_rows[i].want_distance, directed_rows[i].want_oor});
    end
    drain_results();

    // random phases, limit changed only while idle; last phase without idling
    phase_limits = '{lrfd_pkg::dist_t'(DIST_MAX), lrfd_pkg::dist_t'(0),
                     lrfd_pkg::dist_t'($urandom_range(0, DIST_MAX)),
                     lrfd_pkg::LIMIT_RESET,
                     lrfd_pkg::dist_t'($urandom_range(0, 99999)),
                     lrfd_pkg::dist_t'(DIST_MAX)};
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == PHASE_COUNT - 1)
        quiet = 1'b1;
      write_limit(phase_limits[p]);
      gap_rate = $urandom_range(0, 4);
      run_phase(PHASE_BYTES);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_readings.size() == 0)
      $display("laser_range_frame_decoder_top regression: pass");
    else
      $display("laser_range_frame_decoder_top regression: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/lrfd_pkg.sv
rtl/laser_range_frame_decoder_top.sv
rtl/lrfd_checker.sv
bench/laser_range_frame_decoder_top_test.sv
